>>> hw/rtl/lzwc_pkg.sv
// ---------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the LZW compressor.
// ---------------------------------------------------------------------------
package lzwc_pkg;

    // input commands
    localparam logic [1:0] CMD_DATA   = 2'd0;
    localparam logic [1:0] CMD_BEGIN  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROOT_BITS = 2'd0;
    localparam logic [1:0] REG_MAX_BITS  = 2'd1;
    localparam logic [1:0] REG_GIF_MODE  = 2'd2;

    // configuration reset values
    localparam logic [3:0] ROOT_BITS_RST = 4'd8;
    localparam logic [3:0] MAX_BITS_RST  = 4'd12;

    // root codes that can carry a stale child pointer across a dictionary reset
    localparam int ROOT_SLOTS = 256;

    // request from the control sequencer to the output stage
    typedef struct packed {
        logic       push;      // append a byte to the current run
        logic [7:0] data;
        logic       close;     // end the run of the current transaction
        logic       done;      // run belongs to a finish command
    } out_req_t;

    // status from the output stage
    typedef struct packed {
        logic ready;           // push or close is taken this cycle
    } out_sts_t;

endpackage

>>> hw/rtl/lzwc_out_stage.sv
// ---------------------------------------------------------------------------
// lzwc_out_stage
// Holds back one byte so the last byte of a run can be marked, and drives
// the registered result channel.
// ---------------------------------------------------------------------------
module lzwc_out_stage
    import lzwc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  out_req_t   req,
    output out_sts_t   sts,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic       held_vld_reg;
    logic [7:0] held_byte_reg;
    logic       out_vld_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic       out_free;

    assign out_free  = !out_vld_reg || m_tready;
    assign sts.ready = !held_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (out_vld_reg && m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (req.push && sts.ready) begin
                if (held_vld_reg) begin
                    out_vld_reg  <= 1'b1;
                    out_byte_reg <= held_byte_reg;
                    out_last_reg <= 1'b0;
                    out_done_reg <= 1'b0;
                end
                held_vld_reg  <= 1'b1;
                held_byte_reg <= req.data;
            end else if (req.close && sts.ready && held_vld_reg) begin
                out_vld_reg  <= 1'b1;
                out_byte_reg <= held_byte_reg;
                out_last_reg <= 1'b1;
                out_done_reg <= req.done;
                held_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

>>> hw/rtl/lzw_compressor.sv
// ---------------------------------------------------------------------------
// lzw_compressor
// Variable-width LZW compressor with LSB-first code packing.
// ---------------------------------------------------------------------------
// Input channel s_*: one transaction per command (data byte, begin, finish).
// Result channel m_*: packed code bytes and header bytes; tlast marks the
// last byte a command produces, tuser marks the last byte of a finish.
// Config channel cfg_*: always ready; writes apply at the next begin.
// One command is processed at a time. A data byte that starts a string only
// passes the width check; a match found in the dictionary reads the child
// pointer and walks the sibling chain through the node memory. A new entry is
// written when the walk ends (at once when the prefix has no child yet), and
// the prefix code is packed fragment by fragment (1-3 per code). A full table
// also packs the prefix and a clear code. Begin emits the header (root only in
// GIF mode) and a clear code; finish packs any prefix and the end code, then flushes.
// Child pointers of root codes are qualified by per-root valid bits, other
// entries are rewritten when created, so no clearing pass is needed.
// Reset (aresetn low, synchronous) restores root 8, max 12, no GIF mode and
// an empty dictionary. A stalled receiver stalls the packer once both the
// output register and the held byte are occupied; nothing is dropped.
// ---------------------------------------------------------------------------
module lzw_compressor
    import lzwc_pkg::*;
#(
    parameter int MAX_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [1:0] cmd, [9:2] data_byte, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // last_of_run
    output logic        m_tuser,    // [0] stream_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_data
);

    localparam int DEPTH = 1 << MAX_BITS;
    localparam int CW    = MAX_BITS + 1;          // code counter width
    localparam int WW    = $clog2(MAX_BITS + 1);  // code width field
    localparam int NW    = 2 * CW + 8;            // node word: child, sibling, symbol

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHILD    = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;
    localparam logic [3:0] S_ENTRY    = 4'd3;
    localparam logic [3:0] S_PACK     = 4'd4;
    localparam logic [3:0] S_GROW     = 4'd5;
    localparam logic [3:0] S_FULL_CLR = 4'd6;
    localparam logic [3:0] S_FULL_INI = 4'd7;
    localparam logic [3:0] S_HDR_ROOT = 4'd8;
    localparam logic [3:0] S_HDR_MAX  = 4'd9;
    localparam logic [3:0] S_BEG_CLR  = 4'd10;
    localparam logic [3:0] S_FIN_END  = 4'd11;
    localparam logic [3:0] S_FIN_FLSH = 4'd12;
    localparam logic [3:0] S_CLOSE    = 4'd13;

    // configuration
    logic [3:0] cfg_root_reg, cfg_max_reg;
    logic       cfg_gif_reg;
    logic [3:0] cur_root_reg, cur_max_reg;
    logic       cur_gif_reg;
    logic [3:0] new_root, new_max;

    // sequencer
    logic [3:0]          state_reg, ret_reg;
    logic [1:0]          cmd_reg;
    logic [7:0]          sym_reg;
    logic [MAX_BITS-1:0] pend_reg, node_reg;
    logic                pend_vld_reg;
    logic [CW-1:0]       nfc_reg, limit_reg;
    logic [WW-1:0]       cw_reg;
    logic [ROOT_SLOTS-1:0] root_vld_reg;

    // packer
    logic [7:0]          acc_reg;
    logic [3:0]          fill_reg;
    logic [MAX_BITS-1:0] code_sh_reg;
    logic [WW-1:0]       rem_reg;

    // memories
    logic [CW-1:0] child_mem [DEPTH];
    logic [NW-CW-1:0] node_mem [DEPTH];
    logic                ch_we, ch_re, nd_we, nd_re;
    logic [MAX_BITS-1:0] ch_waddr, ch_raddr, nd_waddr, nd_raddr;
    logic [CW-1:0]       ch_wdata, ch_q;
    logic [NW-CW-1:0]    nd_wdata, nd_q;

    out_req_t oreq;
    out_sts_t osts;

    logic [1:0]          in_cmd;
    logic [7:0]          in_byte;
    logic [CW-1:0]       clear_code;
    logic [CW-1:0]       child_val;
    logic [CW-1:0]       sib_val;
    logic [7:0]          sym_val;
    logic                p_is_root;
    logic                e_is_root;
    logic [MAX_BITS-1:0] e_addr;

    // packer step
    logic       pk_full;
    logic [3:0] pk_fill0, pk_room, pk_n;
    logic [7:0] pk_acc0, pk_bits, pk_acc_new;
    logic       pk_stall;

    assign in_cmd  = s_tdata[1:0];
    assign in_byte = s_tdata[9:2];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    // clamp of the header fields, applied at begin
    always_comb begin
        new_root = cfg_root_reg;
        if (new_root < 4'd2) new_root = 4'd2;
        if (new_root > 4'd8) new_root = 4'd8;
        new_max = cfg_max_reg;
        if ({1'b0, new_max} < {1'b0, new_root} + 5'd1) new_max = new_root + 4'd1;
        if ({1'b0, new_max} > 5'(MAX_BITS)) new_max = 4'(MAX_BITS);
    end

    assign clear_code = CW'(1) << cur_root_reg;
    assign e_addr     = nfc_reg[MAX_BITS-1:0];
    assign p_is_root  = (pend_reg < MAX_BITS'(ROOT_SLOTS));
    assign e_is_root  = (e_addr < MAX_BITS'(ROOT_SLOTS));
    assign child_val  = (p_is_root && !root_vld_reg[pend_reg[7:0]]) ? '0 : ch_q;
    assign sib_val    = nd_q[NW-CW-1:8];
    assign sym_val    = nd_q[7:0];

    // one fragment of a code per cycle while the output stage takes full bytes; a full accumulator leaves first
    always_comb begin
        pk_full    = (fill_reg == 4'd8);
        pk_fill0   = pk_full ? 4'd0 : fill_reg;
        pk_acc0    = pk_full ? 8'd0 : acc_reg;
        pk_room    = 4'd8 - pk_fill0;
        pk_n       = ({{(8-WW){1'b0}}, rem_reg} < {4'd0, pk_room}) ? 4'(rem_reg) : pk_room;
        pk_bits    = code_sh_reg[7:0] & ~(8'hff << pk_n);
        pk_acc_new = pk_acc0 | (pk_bits << pk_fill0);
        pk_stall   = pk_full && !osts.ready;
    end

    // memory port control
    always_comb begin
        ch_we    = 1'b0;
        ch_re    = 1'b0;
        ch_waddr = e_addr;
        ch_raddr = pend_reg;
        ch_wdata = '0;
        nd_we    = 1'b0;
        nd_re    = 1'b0;
        nd_waddr = e_addr;
        nd_raddr = child_val[MAX_BITS-1:0];
        nd_wdata = {{CW{1'b0}}, sym_reg};
        oreq     = '0;
        case (state_reg)
            S_IDLE: begin
                ch_re = s_tvalid && (in_cmd == CMD_DATA) && pend_vld_reg;
            end
            S_CHILD: begin
                if (child_val == '0) begin
                    ch_we    = 1'b1;
                    ch_waddr = pend_reg;
                    ch_wdata = nfc_reg;
                end else begin
                    nd_re = 1'b1;
                end
            end
            S_WALK: begin
                if (sib_val != '0 && sym_val != sym_reg) begin
                    nd_re    = 1'b1;
                    nd_raddr = sib_val[MAX_BITS-1:0];
                end else if (sym_val != sym_reg) begin
                    nd_we    = 1'b1;
                    nd_waddr = node_reg;
                    nd_wdata = {nfc_reg, sym_val};
                end
            end
            S_ENTRY: begin
                ch_we = 1'b1;
                nd_we = 1'b1;
            end
            S_PACK: begin
                oreq.push = pk_full;
                oreq.data = acc_reg;
            end
            S_HDR_ROOT: begin
                oreq.push = 1'b1;
                oreq.data = {4'd0, cur_root_reg};
            end
            S_HDR_MAX: begin
                oreq.push = 1'b1;
                oreq.data = {4'd0, cur_max_reg};
            end
            S_FIN_FLSH: begin
                oreq.push = (fill_reg != 4'd0);
                oreq.data = acc_reg;
            end
            S_CLOSE: begin
                oreq.close = 1'b1;
                oreq.done  = (cmd_reg == CMD_FINISH);
            end
            default: begin
            end
        endcase
    end

    // dictionary memories; a read and a write never hit the same entry in
    // one cycle since the sequencer orders them in separate states
    always_ff @(posedge aclk) begin
        if (ch_we) child_mem[ch_waddr] <= ch_wdata;
        if (ch_re) ch_q <= child_mem[ch_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) node_mem[nd_waddr] <= nd_wdata;
        if (nd_re) nd_q <= node_mem[nd_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_root_reg <= ROOT_BITS_RST;
            cfg_max_reg  <= MAX_BITS_RST;
            cfg_gif_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_ROOT_BITS: cfg_root_reg <= cfg_data;
                REG_MAX_BITS:  cfg_max_reg  <= cfg_data;
                REG_GIF_MODE:  cfg_gif_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            cur_root_reg <= ROOT_BITS_RST;
            cur_max_reg  <= (MAX_BITS < 12) ? 4'(MAX_BITS) : MAX_BITS_RST;
            cur_gif_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            pend_reg     <= '0;
            nfc_reg      <= CW'(ROOT_SLOTS + 2);
            cw_reg       <= WW'(9);
            limit_reg    <= CW'(1) << 9;
            root_vld_reg <= '0;
            acc_reg      <= '0;
            fill_reg     <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg <= in_cmd;
                        sym_reg <= in_byte & ~(8'hff << cur_root_reg);
                        case (in_cmd)
                            CMD_DATA: begin
                                if (!pend_vld_reg) begin
                                    pend_reg     <= MAX_BITS'(in_byte & ~(8'hff << cur_root_reg));
                                    pend_vld_reg <= 1'b1;
                                    state_reg    <= S_GROW;
                                end else begin
                                    state_reg <= S_CHILD;
                                end
                            end
                            CMD_BEGIN: begin
                                cur_root_reg <= new_root;
                                cur_max_reg  <= new_max;
                                cur_gif_reg  <= cfg_gif_reg;
                                nfc_reg      <= (CW'(1) << new_root) + CW'(2);
                                cw_reg       <= WW'(new_root) + WW'(1);
                                limit_reg    <= CW'(1) << (new_root + 4'd1);
                                pend_vld_reg <= 1'b0;
                                pend_reg     <= '0;
                                root_vld_reg <= '0;
                                acc_reg      <= '0;
                                fill_reg     <= '0;
                                state_reg    <= S_HDR_ROOT;
                            end
                            CMD_FINISH: begin
                                if (pend_vld_reg) begin
                                    code_sh_reg <= pend_reg;
                                    rem_reg     <= cw_reg;
                                    ret_reg     <= S_FIN_END;
                                    state_reg   <= S_PACK;
                                end else begin
                                    state_reg <= S_FIN_END;
                                end
                            end
                            default: state_reg <= S_CLOSE;
                        endcase
                    end
                end
                S_CHILD: begin
                    if (child_val == '0) begin
                        if (p_is_root) root_vld_reg[pend_reg[7:0]] <= 1'b1;
                        state_reg <= S_ENTRY;
                    end else begin
                        node_reg  <= child_val[MAX_BITS-1:0];
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (sib_val != '0 && sym_val != sym_reg) begin
                        node_reg <= sib_val[MAX_BITS-1:0];
                    end else if (sym_val == sym_reg) begin
                        pend_reg  <= node_reg;
                        state_reg <= S_GROW;
                    end else begin
                        state_reg <= S_ENTRY;
                    end
                end
                S_ENTRY: begin
                    if (e_is_root) root_vld_reg[e_addr[7:0]] <= 1'b0;
                    nfc_reg     <= nfc_reg + CW'(1);
                    code_sh_reg <= pend_reg;
                    rem_reg     <= cw_reg;
                    pend_reg    <= MAX_BITS'(sym_reg);
                    ret_reg     <= S_GROW;
                    state_reg   <= S_PACK;
                end
                S_PACK: begin
                    if (!pk_stall) begin
                        acc_reg     <= pk_acc_new;
                        fill_reg    <= pk_fill0 + pk_n;
                        code_sh_reg <= code_sh_reg >> pk_n;
                        rem_reg     <= rem_reg - WW'(pk_n);
                        if (rem_reg == WW'(pk_n)) state_reg <= ret_reg;
                    end
                end
                S_GROW: begin
                    state_reg <= S_CLOSE;
                    if (nfc_reg > limit_reg) begin
                        if ({1'b0, cw_reg} >= (WW+1)'(cur_max_reg)) begin
                            code_sh_reg <= pend_reg;
                            rem_reg     <= cw_reg;
                            ret_reg     <= S_FULL_CLR;
                            state_reg   <= S_PACK;
                        end else begin
                            cw_reg <= cw_reg + WW'(1);
                            if ({1'b0, cw_reg} + (WW+1)'(1) >= (WW+1)'(cur_max_reg)) begin
                                limit_reg <= (limit_reg << 1) - CW'(1);
                            end else begin
                                limit_reg <= limit_reg << 1;
                            end
                        end
                    end
                end
                S_FULL_CLR: begin
                    code_sh_reg <= clear_code[MAX_BITS-1:0];
                    rem_reg     <= cw_reg;
                    ret_reg     <= S_FULL_INI;
                    state_reg   <= S_PACK;
                end
                S_FULL_INI: begin
                    nfc_reg      <= clear_code + CW'(2);
                    cw_reg       <= WW'(cur_root_reg) + WW'(1);
                    limit_reg    <= CW'(1) << (cur_root_reg + 4'd1);
                    pend_vld_reg <= 1'b0;
                    pend_reg     <= '0;
                    root_vld_reg <= '0;
                    state_reg    <= S_CLOSE;
                end
                S_HDR_ROOT: begin
                    if (osts.ready) state_reg <= cur_gif_reg ? S_BEG_CLR : S_HDR_MAX;
                end
                S_HDR_MAX: begin
                    if (osts.ready) state_reg <= S_BEG_CLR;
                end
                S_BEG_CLR: begin
                    code_sh_reg <= clear_code[MAX_BITS-1:0];
                    rem_reg     <= cw_reg;
                    ret_reg     <= S_CLOSE;
                    state_reg   <= S_PACK;
                end
                S_FIN_END: begin
                    code_sh_reg <= clear_code[MAX_BITS-1:0] + MAX_BITS'(1);
                    rem_reg     <= cw_reg;
                    ret_reg     <= S_FIN_FLSH;
                    state_reg   <= S_PACK;
                end
                S_FIN_FLSH: begin
                    if (fill_reg == 4'd0 || osts.ready) begin
                        acc_reg      <= '0;
                        fill_reg     <= '0;
                        pend_vld_reg <= 1'b0;
                        pend_reg     <= '0;
                        state_reg    <= S_CLOSE;
                    end
                end
                S_CLOSE: begin
                    if (osts.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    lzwc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (oreq),
        .sts      (osts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hw/rtl/lzwc_checker.sv
// ---------------------------------------------------------------------------
// lzwc_checker
// Port-level checks of the LZW compressor, bound to the top level.
// ---------------------------------------------------------------------------
module lzwc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // stream end only on the last byte of a run
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("stream_done without last_of_run");

    // one command at a time
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lzw_compressor lzwc_checker u_lzwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZW compressor: commands are streamed in, a
// local dictionary model predicts every packed output byte with its tlast
// and tuser flags, and the monitor compares each result transaction in order.
// ---------------------------------------------------------------------------
module tb_top;
    import lzwc_pkg::*;

    localparam int TBL_BITS = 12;
    localparam int TBL_SIZE = 1 << TBL_BITS;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] sym;
    } lzw_cmd_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       done;
    } lzw_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [3:0]  cfg_data = '0;

    lzw_compressor #(.MAX_BITS(TBL_BITS)) dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [3:0]  reg_root, reg_max;
    logic        reg_gif;
    int unsigned act_root, act_max;
    logic [12:0] child_tab [TBL_SIZE];
    logic [12:0] sib_tab [TBL_SIZE];
    logic [7:0]  sym_tab [TBL_SIZE];
    int unsigned prefix_code, free_code, code_w, w_limit, acc, fill;
    bit          prefix_ok;
    lzw_byte_t   step_bytes [$];

    lzw_cmd_t    send_q [$];
    lzw_byte_t   expect_q [$];
    int          n_err = 0, n_match = 0, n_sent = 0, n_done_runs = 0;
    int          send_idle = 0, recv_stall = 0;
    bit          hold_off = 0;
    int          wdog = 0;

    function automatic void push_byte(int unsigned b);
        lzw_byte_t r;
        r.byte_val = b[7:0];
        r.last = 1'b0;
        r.done = 1'b0;
        step_bytes.push_back(r);
    endfunction

    function automatic void pack_code(int unsigned code);
        int unsigned got, room, n;
        got = 0;
        while (got < code_w) begin
            if (fill >= 8) begin
                push_byte(acc);
                acc = 0;
                fill = 0;
            end
            room = 8 - fill;
            n = code_w - got;
            if (n > room) n = room;
            acc = acc | ((((code >> got) & ((1 << n) - 1)) << fill) & 8'hff);
            fill += n;
            got += n;
        end
    endfunction

    function automatic void take_config();
        act_root = reg_root;
        if (act_root < 2) act_root = 2;
        if (act_root > 8) act_root = 8;
        act_max = reg_max;
        if (act_max < act_root + 1) act_max = act_root + 1;
        if (act_max > TBL_BITS) act_max = TBL_BITS;
    endfunction

    function automatic void restart_dict();
        foreach (child_tab[i]) child_tab[i] = '0;
        free_code = (1 << act_root) + 2;
        code_w = act_root + 1;
        w_limit = 1 << code_w;
        prefix_ok = 0;
        prefix_code = 0;
    endfunction

    function automatic void add_symbol(int unsigned s);
        int unsigned p, c, guard;
        bit hit;
        if (!prefix_ok) begin
            prefix_code = s;
            prefix_ok = 1;
        end else begin
            p = prefix_code % TBL_SIZE;
            c = child_tab[p];
            hit = 0;
            if (c == 0) begin
                child_tab[p] = free_code[12:0];
            end else begin
                guard = 0;
                c = c % TBL_SIZE;
                while (sib_tab[c] != 0 && sym_tab[c] != s && guard < TBL_SIZE) begin
                    c = sib_tab[c] % TBL_SIZE;
                    guard++;
                end
                if (sym_tab[c] == s) hit = 1;
                else sib_tab[c] = free_code[12:0];
            end
            if (hit) begin
                prefix_code = c;
            end else begin
                sym_tab[free_code % TBL_SIZE] = s[7:0];
                child_tab[free_code % TBL_SIZE] = '0;
                sib_tab[free_code % TBL_SIZE] = '0;
                free_code++;
                pack_code(prefix_code);
                prefix_code = s;
            end
        end
        if (free_code > w_limit) begin
            if (code_w >= act_max) begin
                // table full: flush prefix, send clear, start over
                pack_code(prefix_code);
                pack_code(1 << act_root);
                restart_dict();
            end else begin
                code_w++;
                w_limit = w_limit << 1;
                if (code_w >= act_max) w_limit--;
            end
        end
    endfunction

    function automatic void predict_bytes(lzw_cmd_t it);
        step_bytes.delete();
        case (it.cmd)
            CMD_BEGIN: begin
                take_config();
                restart_dict();
                acc = 0;
                fill = 0;
                push_byte(act_root);
                if (!reg_gif) push_byte(act_max);
                pack_code(1 << act_root);
            end
            CMD_DATA: add_symbol(it.sym & ((1 << act_root) - 1));
            CMD_FINISH: begin
                if (prefix_ok) pack_code(prefix_code);
                pack_code((1 << act_root) + 1);
                if (fill > 0) push_byte(acc);
                acc = 0;
                fill = 0;
                prefix_ok = 0;
                prefix_code = 0;
                if (step_bytes.size() > 0) step_bytes[$].done = 1'b1;
            end
            default: ;
        endcase
        if (step_bytes.size() > 0) step_bytes[$].last = 1'b1;
        foreach (step_bytes[i]) expect_q.push_back(step_bytes[i]);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_bytes(lzw_cmd_t'({s_tdata[1:0], s_tdata[9:2]}));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_q.size() > 0 && !($urandom_range(99) < send_idle)) begin
                    lzw_cmd_t it;
                    it = send_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, it.sym, it.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                lzw_byte_t exp_b;
                if (expect_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected output byte %h last %b done %b",
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    exp_b = expect_q.pop_front();
                    if (exp_b.byte_val !== m_tdata || exp_b.last !== m_tlast ||
                        exp_b.done !== m_tuser) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     exp_b.byte_val, exp_b.last, exp_b.done,
                                     m_tdata, m_tlast, m_tuser);
                    end else begin
                        n_match++;
                        if (m_tuser) n_done_runs++;
                    end
                end
            end
            m_tready <= !hold_off && !($urandom_range(99) < recv_stall);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || hold_off)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expect_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_drained();
        while (send_q.size() > 0 || s_tvalid || expect_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROOT_BITS: reg_root = val;
            REG_MAX_BITS:  reg_max = val;
            REG_GIF_MODE:  reg_gif = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic void queue_cmd(logic [1:0] c, logic [7:0] d);
        lzw_cmd_t it;
        it.cmd = c;
        it.sym = d;
        send_q.push_back(it);
    endfunction

    // well-formed stream; symbols mostly up to alpha, so a small alpha fills and resets small tables
    function automatic void queue_stream(int n, int alpha);
        queue_cmd(CMD_BEGIN, 8'($urandom()));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) queue_cmd(CMD_DATA, 8'($urandom()));
            else queue_cmd(CMD_DATA, 8'($urandom_range(alpha)));
        end
        queue_cmd(CMD_FINISH, 8'($urandom()));
    endfunction

    initial begin
        reg_root = ROOT_BITS_RST;
        reg_max = MAX_BITS_RST;
        reg_gif = 1'b0;
        take_config();
        foreach (sib_tab[i]) sib_tab[i] = '0;
        foreach (sym_tab[i]) sym_tab[i] = '0;
        restart_dict();
        acc = 0;
        fill = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: data before begin, unknown command, finish with no prefix,
        // extremes of data byte, repeats hitting the dictionary
        queue_cmd(CMD_DATA, 8'hff);
        queue_cmd(CMD_DATA, 8'h00);
        queue_cmd(2'd3, 8'haa);
        queue_cmd(CMD_FINISH, 8'h00);
        queue_cmd(CMD_FINISH, 8'h55);
        queue_cmd(CMD_BEGIN, 8'h00);
        queue_cmd(CMD_DATA, 8'h00);
        queue_cmd(CMD_DATA, 8'hff);
        queue_cmd(CMD_DATA, 8'h00);
        queue_cmd(CMD_DATA, 8'hff);
        queue_cmd(CMD_DATA, 8'h00);
        queue_cmd(CMD_DATA, 8'hff);
        queue_cmd(CMD_FINISH, 8'hff);
        wait_drained();

        // out-of-range root and max in GIF mode: the clamps to root 2 and max 12
        write_reg(REG_ROOT_BITS, 4'd0);
        write_reg(REG_MAX_BITS, 4'd15);
        write_reg(REG_GIF_MODE, 4'd1);
        queue_cmd(CMD_BEGIN, 8'h00);
        for (int i = 0; i < 10; i++) queue_cmd(CMD_DATA, i[7:0] * 8'd37);
        queue_cmd(CMD_FINISH, 8'h00);
        wait_drained();

        // random phases with idling profiles and config settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 85; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 85; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            write_reg(REG_ROOT_BITS, (ph == 0) ? 4'd2 : (ph == 1) ? 4'd8 :
                      4'($urandom_range(15)));
            write_reg(REG_MAX_BITS, (ph == 0) ? 4'd3 : (ph == 1) ? 4'd12 :
                      4'($urandom_range(15)));
            write_reg(REG_GIF_MODE, {3'd0, ph[0]});
            queue_stream(18, 3);
            queue_stream(10, 255);
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 1;
                queue_stream(10, 2);
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            wait_drained();
        end
        send_idle = 0;
        recv_stall = 0;
        write_reg(REG_ROOT_BITS, ROOT_BITS_RST);
        write_reg(REG_MAX_BITS, MAX_BITS_RST);

        $display("sent %0d commands; %0d output bytes matched, %0d finish runs",
                 n_sent, n_match, n_done_runs);
        $display("covered clamped roots/widths, gif and full headers, table resets");
        if (n_err == 0 && expect_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d errors, %0d results never arrived", n_err, expect_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> lzw_compressor.f
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_out_stage.sv
hw/rtl/lzw_compressor.sv
hw/rtl/lzwc_checker.sv
tb/tb_top.sv
